FILE: src/jpeg_marker_stream_sniffer_macros.svh
// ----------------------------------------------------------------------------
// JPEG marker stream sniffer assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef JPEG_MARKER_STREAM_SNIFFER_MACROS_SVH
`define JPEG_MARKER_STREAM_SNIFFER_MACROS_SVH

// same-cycle implication
`define JMSS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jmss: same-cycle check failed");

// next-cycle implication
`define JMSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jmss: next-cycle check failed");

`endif

FILE: src/jmss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG marker stream sniffer package
// Parse phases, marker codes, register indexes and the verdict record.
// ----------------------------------------------------------------------------
package jmss_pkg;

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_SECOND,
      PH_MARK,
      PH_CODE,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_BODY,
      PH_REJECT
   } phase_type;

   localparam logic [7:0] MARKER_FILL = 8'hFF;
   localparam logic [7:0] MARKER_SOI  = 8'hD8;
   localparam logic [7:0] MARKER_DHT  = 8'hC4;
   localparam logic [7:0] MARKER_DAC  = 8'hCC;
   localparam logic [7:0] MARKER_DQT  = 8'hDB;
   localparam logic [7:0] MARKER_DRI  = 8'hDD;
   localparam logic [7:0] MARKER_COM  = 8'hFE;
   localparam logic [7:0] MARKER_APP0 = 8'hE0;
   localparam logic [7:0] MARKER_APP1 = 8'hE1;
   localparam logic [7:0] MARKER_APPF = 8'hEF;
   localparam logic [7:0] MARKER_JPG  = 8'hC8;

   localparam logic [1:0] CONF_POSSIBLE = 2'd0;
   localparam logic [1:0] CONF_LIKELY   = 2'd1;
   localparam logic [1:0] CONF_MAX      = 2'd2;

   localparam logic [15:0] MIN_SEG_LEN = 16'd2;
   localparam logic [15:0] MIN_SOF_LEN = 16'd10;
   localparam logic [15:0] MIN_APP_LEN = 16'd6;

   localparam logic [1:0] CSR_SCAN_LIMIT       = 2'd0;
   localparam logic [1:0] CSR_MARKER_THRESHOLD = 2'd1;

   localparam logic [23:0] SCAN_LIMIT_RESET = 24'd204800;
   localparam logic [7:0]  THRESHOLD_RESET  = 8'd5;

   typedef struct packed {
      logic [3:0]  frame_kind;
      logic [15:0] image_height;
      logic [15:0] image_width;
      logic        frame_found;
      logic [1:0]  confidence;
      logic        detected;
   } verdict_type;

   function automatic logic is_sof(input logic [7:0] m);
      return (m[7:4] == 4'hC) && (m != MARKER_DHT) && (m != MARKER_JPG)
             && (m != MARKER_DAC);
   endfunction

   function automatic logic is_counted(input logic [7:0] m);
      logic hit;
      case (m) inside
         MARKER_DHT, MARKER_DAC, MARKER_DQT, MARKER_DRI, MARKER_COM: hit = 1'b1;
         [MARKER_APP0:MARKER_APPF]:                                  hit = 1'b1;
         default:                                                    hit = 1'b0;
      endcase
      return hit;
   endfunction

   // "JFIF" for APP0, "Exif" for APP1
   function automatic logic [7:0] sig_byte(input logic exif, input logic [1:0] idx);
      logic [7:0] b;
      case ({exif, idx})
         3'b000:  b = 8'h4A;
         3'b001:  b = 8'h46;
         3'b010:  b = 8'h49;
         3'b011:  b = 8'h46;
         3'b100:  b = 8'h45;
         3'b101:  b = 8'h78;
         3'b110:  b = 8'h69;
         default: b = 8'h66;
      endcase
      return b;
   endfunction

endpackage

FILE: src/jmss_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG marker stream sniffer parse stage
// Per-file parse state; advances one byte per step and forms the verdict.
// ----------------------------------------------------------------------------
module jmss_parser #(
   parameter int OFFSET_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            data_byte,
   input  logic                  last,
   input  logic [23:0]           scan_limit,
   input  logic [7:0]            count_threshold,
   output jmss_pkg::verdict_type verdict
);

   localparam int CMP_W = (OFFSET_BITS > 24) ? OFFSET_BITS : 24;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

   jmss_pkg::phase_type    phase_ff, phase_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [15:0]            rem_ff, rem_in;
   logic [15:0]            len_ff, len_in;
   logic [7:0]             marker_ff, marker_in;
   logic [7:0]             count_ff, count_in;
   logic [1:0]             conf_ff, conf_in;
   logic                   sig_ok_ff, sig_ok_in;
   logic [15:0]            height_ff, height_in;
   logic [15:0]            width_ff, width_in;
   logic [3:0]             ftype_ff, ftype_in;
   logic                   fvalid_ff, fvalid_in;
   logic                   stopped_ff, stopped_in;

   logic             past_limit;
   logic             do_finish;
   logic [15:0]      pos;
   logic [15:0]      rem_dec;
   logic [15:0]      len_cat;
   logic [1:0]       sig_idx;
   logic             is_app01;
   logic             det;
   logic             fv;

   assign past_limit = CMP_W'(offset_ff) >= CMP_W'(scan_limit);
   assign pos        = len_ff - rem_ff;
   assign rem_dec    = rem_ff - 16'd1;
   assign len_cat    = {len_ff[15:8], data_byte};
   assign sig_idx    = pos[1:0] - 2'd2;
   assign is_app01   = (marker_ff == jmss_pkg::MARKER_APP0)
                       || (marker_ff == jmss_pkg::MARKER_APP1);

   always_comb begin
      phase_in   = phase_ff;
      rem_in     = rem_ff;
      len_in     = len_ff;
      marker_in  = marker_ff;
      count_in   = count_ff;
      conf_in    = conf_ff;
      sig_ok_in  = sig_ok_ff;
      height_in  = height_ff;
      width_in   = width_ff;
      ftype_in   = ftype_ff;
      fvalid_in  = fvalid_ff;
      stopped_in = stopped_ff;
      do_finish  = 1'b0;
      offset_in  = (offset_ff != OFFSET_MAX) ? offset_ff + OFFSET_BITS'(1) : offset_ff;

      if (!stopped_ff) begin
         unique case (phase_ff)
            jmss_pkg::PH_FIRST: begin
               if (data_byte == jmss_pkg::MARKER_FILL) begin
                  phase_in = jmss_pkg::PH_SECOND;
               end else begin
                  phase_in   = jmss_pkg::PH_REJECT;
                  stopped_in = 1'b1;
               end
            end
            jmss_pkg::PH_SECOND: begin
               if (data_byte == jmss_pkg::MARKER_SOI) begin
                  count_in = 8'd1;
                  phase_in = jmss_pkg::PH_MARK;
               end else begin
                  phase_in   = jmss_pkg::PH_REJECT;
                  stopped_in = 1'b1;
               end
            end
            jmss_pkg::PH_MARK: begin
               if (past_limit || data_byte != jmss_pkg::MARKER_FILL) begin
                  stopped_in = 1'b1;
               end else begin
                  phase_in = jmss_pkg::PH_CODE;
               end
            end
            jmss_pkg::PH_CODE: begin
               // a repeated FF is fill and restarts the marker at this offset
               if (data_byte == jmss_pkg::MARKER_FILL) begin
                  if (past_limit) begin
                     stopped_in = 1'b1;
                  end
               end else begin
                  marker_in = data_byte;
                  phase_in  = jmss_pkg::PH_LEN_HI;
               end
            end
            jmss_pkg::PH_LEN_HI: begin
               len_in   = {data_byte, 8'h00};
               phase_in = jmss_pkg::PH_LEN_LO;
            end
            jmss_pkg::PH_LEN_LO: begin
               len_in = len_cat;
               if (len_cat < jmss_pkg::MIN_SEG_LEN) begin
                  stopped_in = 1'b1;
               end else if (jmss_pkg::is_sof(marker_ff)
                            && len_cat < jmss_pkg::MIN_SOF_LEN) begin
                  stopped_in = 1'b1;
               end else if (!jmss_pkg::is_sof(marker_ff)
                            && !jmss_pkg::is_counted(marker_ff)) begin
                  stopped_in = 1'b1;
               end else begin
                  if (jmss_pkg::is_sof(marker_ff)) begin
                     height_in = '0;
                     width_in  = '0;
                  end
                  sig_ok_in = 1'b1;
                  rem_in    = len_cat - jmss_pkg::MIN_SEG_LEN;
                  if (rem_in == '0) begin
                     do_finish = 1'b1;
                  end else begin
                     phase_in = jmss_pkg::PH_BODY;
                  end
               end
            end
            jmss_pkg::PH_BODY: begin
               if (is_app01) begin
                  if (pos >= 16'd2 && pos < 16'd6
                      && data_byte != jmss_pkg::sig_byte(marker_ff[0], sig_idx)) begin
                     sig_ok_in = 1'b0;
                  end
               end else if (jmss_pkg::is_sof(marker_ff)) begin
                  case (pos)
                     16'd3:   height_in = {data_byte, 8'h00};
                     16'd4:   height_in = {height_ff[15:8], data_byte};
                     16'd5:   width_in  = {data_byte, 8'h00};
                     16'd6:   width_in  = {width_ff[15:8], data_byte};
                     default: ;
                  endcase
               end
               rem_in = rem_dec;
               if (rem_dec == '0) begin
                  do_finish = 1'b1;
               end
            end
            jmss_pkg::PH_REJECT: stopped_in = 1'b1;
            default:             stopped_in = 1'b1;
         endcase

         // segment complete: frame header ends parsing, anything else is counted
         if (do_finish) begin
            if (jmss_pkg::is_sof(marker_ff)) begin
               stopped_in = 1'b1;
               if (height_ff != '0 && width_ff != '0) begin
                  fvalid_in = 1'b1;
                  ftype_in  = marker_ff[3:0];
                  conf_in   = (count_ff >= count_threshold || conf_ff == jmss_pkg::CONF_MAX)
                              ? jmss_pkg::CONF_MAX : jmss_pkg::CONF_LIKELY;
               end
            end else begin
               if (is_app01 && len_in >= jmss_pkg::MIN_APP_LEN && sig_ok_in) begin
                  conf_in = jmss_pkg::CONF_MAX;
               end
               if (count_ff != 8'hFF) begin
                  count_in = count_ff + 8'd1;
               end
               phase_in = jmss_pkg::PH_MARK;
            end
         end
      end
   end

   assign det = (phase_in != jmss_pkg::PH_FIRST) && (phase_in != jmss_pkg::PH_SECOND)
                && (phase_in != jmss_pkg::PH_REJECT);
   assign fv  = det && fvalid_in;

   always_comb begin
      verdict.detected     = det;
      verdict.confidence   = det ? conf_in : jmss_pkg::CONF_POSSIBLE;
      verdict.frame_found  = fv;
      verdict.image_width  = fv ? width_in : '0;
      verdict.image_height = fv ? height_in : '0;
      verdict.frame_kind   = fv ? ftype_in : '0;
   end

   // the verdict byte also returns everything to the start-of-file state
   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         phase_ff   <= jmss_pkg::PH_FIRST;
         offset_ff  <= '0;
         rem_ff     <= '0;
         len_ff     <= '0;
         marker_ff  <= '0;
         count_ff   <= '0;
         conf_ff    <= jmss_pkg::CONF_POSSIBLE;
         sig_ok_ff  <= 1'b0;
         height_ff  <= '0;
         width_ff   <= '0;
         ftype_ff   <= '0;
         fvalid_ff  <= 1'b0;
         stopped_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         offset_ff  <= offset_in;
         rem_ff     <= rem_in;
         len_ff     <= len_in;
         marker_ff  <= marker_in;
         count_ff   <= count_in;
         conf_ff    <= conf_in;
         sig_ok_ff  <= sig_ok_in;
         height_ff  <= height_in;
         width_ff   <= width_in;
         ftype_ff   <= ftype_in;
         fvalid_ff  <= fvalid_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

FILE: src/jpeg_marker_stream_sniffer.sv
`timescale 1ns / 1ps
// Verdict path: the final byte sits in the input register and its verdict loads the
//   result register on rsp once any previous verdict there has been taken.
// Throughput: one byte per cycle; only a final byte waits, while the previous
//   verdict is still held on rsp.
// Reset: synchronous, clears parse state and both valid flags and
//   restores scan_limit to 204800 and marker_count_threshold to 5.
// ----------------------------------------------------------------------------
// JPEG marker stream sniffer
// Walks JPEG marker segments of a byte stream and reports one verdict per file.
// ----------------------------------------------------------------------------
`include "jpeg_marker_stream_sniffer_macros.svh"

module jpeg_marker_stream_sniffer #(
   parameter int OFFSET_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // detected, confidence[1:0], frame_found,
                                    // image_width[15:0], image_height[15:0],
                                    // frame_kind[3:0]
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [23:0] csr_wdata
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   jmss_pkg::verdict_type rsp_data_ff;
   jmss_pkg::verdict_type verdict;
   logic [23:0] scan_limit_ff;
   logic [7:0]  threshold_ff;
   logic        move;
   logic        step;

   // a non-final byte never needs the result register
   assign move       = !in_last_ff || !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && move;
   assign req_tready = !in_valid_ff || move;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !move);
   assign rsp_valid_in = (step && in_last_ff) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (step && in_last_ff) begin
         rsp_data_ff <= verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_limit_ff <= jmss_pkg::SCAN_LIMIT_RESET;
         threshold_ff  <= jmss_pkg::THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            jmss_pkg::CSR_SCAN_LIMIT:       scan_limit_ff <= csr_wdata;
            jmss_pkg::CSR_MARKER_THRESHOLD: threshold_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   jmss_parser #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_parser (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .data_byte       (in_byte_ff),
      .last            (in_last_ff),
      .scan_limit      (scan_limit_ff),
      .count_threshold (threshold_ff),
      .verdict         (verdict)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `JMSS_ASSERT_SAME(a_undetected_clear, clock, reset, rsp_tvalid && !rsp_data_ff.detected, rsp_data_ff.confidence == jmss_pkg::CONF_POSSIBLE && !rsp_data_ff.frame_found)
   `JMSS_ASSERT_SAME(a_frame_dims, clock, reset, rsp_tvalid && rsp_data_ff.frame_found, rsp_data_ff.image_width != '0 && rsp_data_ff.image_height != '0 && rsp_data_ff.detected)
   `JMSS_ASSERT_SAME(a_conf_range, clock, reset, rsp_tvalid, rsp_data_ff.confidence != 2'd3)
   `JMSS_ASSERT_NEXT(a_result_from_last, clock, reset, !rsp_valid_ff && !(step && in_last_ff), !rsp_valid_ff)

endmodule

FILE: verif/jpeg_marker_stream_sniffer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG marker stream sniffer testbench
// Streams short byte files (well-formed marker sequences, damaged and truncated
// ones, plain noise) through the sniffer under random stalls on both sides,
// predicts the per-file verdict and checks every verdict field by field.
// ----------------------------------------------------------------------------
module jpeg_marker_stream_sniffer_tb;

   localparam int          CYCLE_LIMIT  = 300000;
   localparam int          DRAIN_CYCLES = 8;
   localparam logic [1:0]  CSR_UNUSED   = 2'd3;
   localparam logic [7:0]  MARKER_SOF0  = 8'hC0;
   localparam logic [7:0]  MARKER_SOF15 = 8'hCF;
   localparam logic [31:0] JFIF_TAG     = "JFIF";
   localparam logic [31:0] EXIF_TAG     = "Exif";
   localparam logic [23:0] OFFSET_MAX   = '1;

   // -------------------------------------------------------------------------
   // Verdict scoreboard: tracks one file's parse state and queues verdicts
   // -------------------------------------------------------------------------
   class jpeg_verdict_board;
      logic [23:0]           scan_limit;
      logic [7:0]            threshold;
      jmss_pkg::phase_type   phase;
      logic [23:0]           offset;
      logic [15:0]           seg_left;
      logic [15:0]           seg_len;
      logic [7:0]            marker;
      logic [7:0]            marker_total;
      logic [1:0]            conf;
      logic                  sig_ok;
      logic [15:0]           height;
      logic [15:0]           width;
      logic [3:0]            kind;
      logic                  frame_ok;
      logic                  stopped;
      jmss_pkg::verdict_type expected_verdicts[$];
      int                    errors;

      function new();
         scan_limit = jmss_pkg::SCAN_LIMIT_RESET;
         threshold  = jmss_pkg::THRESHOLD_RESET;
         errors     = 0;
         clear_file();
      endfunction

      static function logic frame_code(logic [7:0] m);
         return m >= MARKER_SOF0 && m <= MARKER_SOF15 && m != jmss_pkg::MARKER_DHT &&
                m != jmss_pkg::MARKER_JPG && m != jmss_pkg::MARKER_DAC;
      endfunction

      static function logic counted_code(logic [7:0] m);
         return m == jmss_pkg::MARKER_DHT || m == jmss_pkg::MARKER_DAC ||
                m == jmss_pkg::MARKER_DQT || m == jmss_pkg::MARKER_DRI ||
                m == jmss_pkg::MARKER_COM ||
                (m >= jmss_pkg::MARKER_APP0 && m <= jmss_pkg::MARKER_APPF);
      endfunction

      function void clear_file();
         phase        = jmss_pkg::PH_FIRST;
         offset       = '0;
         seg_left     = '0;
         seg_len      = '0;
         marker       = '0;
         marker_total = '0;
         conf         = jmss_pkg::CONF_POSSIBLE;
         sig_ok       = 1'b0;
         height       = '0;
         width        = '0;
         kind         = '0;
         frame_ok     = 1'b0;
         stopped      = 1'b0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [23:0] value);
         if (idx == jmss_pkg::CSR_SCAN_LIMIT)
            scan_limit = value;
         else if (idx == jmss_pkg::CSR_MARKER_THRESHOLD)
            threshold = value[7:0];
      endfunction

      function int outstanding();
         return expected_verdicts.size();
      endfunction

      function void close_segment();
         if (frame_code(marker)) begin
            if (height != 0 && width != 0) begin
               frame_ok = 1'b1;
               kind     = marker[3:0];
               conf     = (marker_total >= threshold || conf == jmss_pkg::CONF_MAX) ?
                          jmss_pkg::CONF_MAX : jmss_pkg::CONF_LIKELY;
            end
            stopped = 1'b1;
            return;
         end
         if ((marker == jmss_pkg::MARKER_APP0 || marker == jmss_pkg::MARKER_APP1) &&
             seg_len >= jmss_pkg::MIN_APP_LEN && sig_ok)
            conf = jmss_pkg::CONF_MAX;
         if (marker_total != 8'hFF)
            marker_total++;
         phase = jmss_pkg::PH_MARK;
      endfunction

      function void parse(logic [7:0] b);
         logic [15:0] pos;
         logic [31:0] tag;
         case (phase)
            jmss_pkg::PH_FIRST: begin
               if (b == jmss_pkg::MARKER_FILL) phase = jmss_pkg::PH_SECOND;
               else begin
                  phase   = jmss_pkg::PH_REJECT;
                  stopped = 1'b1;
               end
            end
            jmss_pkg::PH_SECOND: begin
               if (b == jmss_pkg::MARKER_SOI) begin
                  marker_total = 8'd1;
                  phase        = jmss_pkg::PH_MARK;
               end else begin
                  phase   = jmss_pkg::PH_REJECT;
                  stopped = 1'b1;
               end
            end
            jmss_pkg::PH_MARK: begin
               if (offset >= scan_limit || b != jmss_pkg::MARKER_FILL) stopped = 1'b1;
               else phase = jmss_pkg::PH_CODE;
            end
            jmss_pkg::PH_CODE: begin
               // repeated FF is fill; it restarts the marker at this offset
               if (b == jmss_pkg::MARKER_FILL) begin
                  if (offset >= scan_limit) stopped = 1'b1;
               end else begin
                  marker = b;
                  phase  = jmss_pkg::PH_LEN_HI;
               end
            end
            jmss_pkg::PH_LEN_HI: begin
               seg_len = {b, 8'h00};
               phase   = jmss_pkg::PH_LEN_LO;
            end
            jmss_pkg::PH_LEN_LO: begin
               seg_len[7:0] = b;
               if (seg_len < jmss_pkg::MIN_SEG_LEN) stopped = 1'b1;
               else if (frame_code(marker) && seg_len < jmss_pkg::MIN_SOF_LEN)
                  stopped = 1'b1;
               else if (!frame_code(marker) && !counted_code(marker)) stopped = 1'b1;
               else begin
                  if (frame_code(marker)) begin
                     height = '0;
                     width  = '0;
                  end
                  sig_ok   = 1'b1;
                  seg_left = seg_len - jmss_pkg::MIN_SEG_LEN;
                  if (seg_left == 0) close_segment();
                  else phase = jmss_pkg::PH_BODY;
               end
            end
            jmss_pkg::PH_BODY: begin
               pos = seg_len - seg_left;
               if (marker == jmss_pkg::MARKER_APP0 || marker == jmss_pkg::MARKER_APP1) begin
                  tag = (marker == jmss_pkg::MARKER_APP0) ? JFIF_TAG : EXIF_TAG;
                  if (pos >= 2 && pos < 6 && b != tag[31 - 8 * (pos - 2) -: 8])
                     sig_ok = 1'b0;
               end else if (frame_code(marker)) begin
                  case (pos)
                     16'd3:   height[15:8] = b;
                     16'd4:   height[7:0]  = b;
                     16'd5:   width[15:8]  = b;
                     16'd6:   width[7:0]   = b;
                     default: ;
                  endcase
               end
               seg_left--;
               if (seg_left == 0) close_segment();
            end
            default: stopped = 1'b1;
         endcase
      endfunction

      function void accept_byte(logic [7:0] b, logic last);
         jmss_pkg::verdict_type v;
         logic                  det;
         if (!stopped) parse(b);
         if (offset != OFFSET_MAX) offset++;
         if (last) begin
            det = phase != jmss_pkg::PH_FIRST && phase != jmss_pkg::PH_SECOND &&
                  phase != jmss_pkg::PH_REJECT;
            v = '0;
            v.detected = det;
            if (det) begin
               v.confidence  = conf;
               v.frame_found = frame_ok;
               if (frame_ok) begin
                  v.image_width  = width;
                  v.image_height = height;
                  v.frame_kind   = kind;
               end
            end
            expected_verdicts.push_back(v);
            clear_file();
         end
      endfunction

      function void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
         if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name,
                     exp_v, act_v);
         end
      endfunction

      function void check_verdict(jmss_pkg::verdict_type got);
         jmss_pkg::verdict_type want;
         if (expected_verdicts.size() == 0) begin
            errors++;
            $display("%0t: unexpected verdict: expected none, actual %h", $time, got);
            return;
         end
         want = expected_verdicts.pop_front();
         check_field("detected", want.detected, got.detected);
         check_field("confidence", want.confidence, got.confidence);
         check_field("frame_found", want.frame_found, got.frame_found);
         check_field("image_width", want.image_width, got.image_width);
         check_field("image_height", want.image_height, got.image_height);
         check_field("frame_kind", want.frame_kind, got.frame_kind);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [23:0] csr_wdata;

   jpeg_verdict_board sb = new();
   bit                req_idle_on;
   bit                rsp_idle_on;
   int                cycles;
   logic [7:0]        file_bytes[$];

   jpeg_marker_stream_sniffer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_verdict(jmss_pkg::verdict_type'(rsp_tdata));
   end

   // result side back-pressure
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_idle_on && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   function automatic void add_segment(ref logic [7:0] q[$], input logic [7:0] code,
                                       input int body_len, input logic [31:0] tag,
                                       input int tag_len);
      logic [15:0] len;
      len = 16'(body_len + 2);
      q.push_back(code);
      q.push_back(len[15:8]);
      q.push_back(len[7:0]);
      for (int i = 0; i < body_len; i++)
         q.push_back(i < tag_len ? tag[31 - 8 * i -: 8] : 8'($urandom));
   endfunction

   function automatic void build_file(ref logic [7:0] q[$]);
      logic [7:0]  code;
      logic [15:0] len;
      logic [15:0] h;
      logic [15:0] w;
      int          blen;
      int          cut;
      q.delete();
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 8)) q.push_back(8'($urandom));
         return;
      end
      q.push_back(jmss_pkg::MARKER_FILL);
      q.push_back(jmss_pkg::MARKER_SOI);
      repeat ($urandom_range(0, 3)) begin
         q.push_back(jmss_pkg::MARKER_FILL);
         if ($urandom_range(0, 5) == 0) q.push_back(jmss_pkg::MARKER_FILL);
         blen = $urandom_range(0, 3);
         case ($urandom_range(0, 9))
            0: add_segment(q, jmss_pkg::MARKER_DHT, blen, '0, 0);
            1: add_segment(q, jmss_pkg::MARKER_DAC, blen, '0, 0);
            2: add_segment(q, jmss_pkg::MARKER_DQT, blen, '0, 0);
            3: add_segment(q, jmss_pkg::MARKER_DRI, blen, '0, 0);
            4: add_segment(q, jmss_pkg::MARKER_COM, blen, '0, 0);
            // short bodies give an APP segment too short for its signature
            5: add_segment(q, jmss_pkg::MARKER_APP0, $urandom_range(2, 6), JFIF_TAG, 4);
            6: add_segment(q, jmss_pkg::MARKER_APP1, $urandom_range(2, 6), EXIF_TAG, 4);
            7: add_segment(q, 8'($urandom_range(jmss_pkg::MARKER_APP0,
                                                jmss_pkg::MARKER_APPF)),
                           $urandom_range(3, 5), JFIF_TAG, $urandom_range(0, 4));
            8: begin
               // arbitrary code with a degenerate or runaway length
               q.push_back(8'($urandom));
               len = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'hFFFF;
               q.push_back(len[15:8]);
               q.push_back(len[7:0]);
            end
            default: add_segment(q, jmss_pkg::MARKER_COM, blen, '0, 0);
         endcase
      end
      if ($urandom_range(0, 3) != 0) begin
         do code = 8'($urandom_range(MARKER_SOF0, MARKER_SOF15));
         while (!jpeg_verdict_board::frame_code(code));
         len = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 9)) :
                                             16'($urandom_range(10, 12));
         h = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
         w = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
         q.push_back(jmss_pkg::MARKER_FILL);
         q.push_back(code);
         q.push_back(len[15:8]);
         q.push_back(len[7:0]);
         for (int i = 0; i + 2 < int'(len); i++) begin
            case (i)
               1:       q.push_back(h[15:8]);
               2:       q.push_back(h[7:0]);
               3:       q.push_back(w[15:8]);
               4:       q.push_back(w[7:0]);
               default: q.push_back(8'($urandom));
            endcase
         end
      end
      repeat ($urandom_range(0, 2)) q.push_back(8'($urandom));
      if ($urandom_range(0, 4) == 0) begin
         cut = $urandom_range(1, q.size());
         while (q.size() > cut) void'(q.pop_back());
      end
      if ($urandom_range(0, 7) == 0)
         q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.accept_byte(b, last);
   endtask

   task automatic send_file(input logic [7:0] q[$]);
      foreach (q[i]) send_byte(q[i], i == q.size() - 1);
   endtask

   // hold the sender until every verdict is back and the pipe is empty
   task automatic drain();
      req_tvalid <= 1'b0;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.write_reg(idx, value);
   endtask

   task automatic run_files(input int count, input bit idle);
      repeat (count) begin
         req_idle_on = idle && $urandom_range(0, 3) != 0;
         rsp_idle_on = idle && $urandom_range(0, 3) != 0;
         build_file(file_bytes);
         send_file(file_bytes);
      end
   endtask

   initial begin
      cycles      = 0;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_we     <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: short file, bad marker start, length below 2, then a frame
      // header behind a fill byte with maximum dimensions and a trailing byte
      send_file('{jmss_pkg::MARKER_FILL});
      send_file('{jmss_pkg::MARKER_FILL, jmss_pkg::MARKER_SOI, 8'h00});
      send_file('{jmss_pkg::MARKER_FILL, jmss_pkg::MARKER_SOI, jmss_pkg::MARKER_FILL,
                  jmss_pkg::MARKER_COM, 8'h00, 8'h01});
      send_file('{jmss_pkg::MARKER_FILL, jmss_pkg::MARKER_SOI, jmss_pkg::MARKER_FILL,
                  jmss_pkg::MARKER_FILL, MARKER_SOF0,
                  8'h00, 8'h0A, 8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00,
                  8'h00, 8'h5A});
      drain();

      write_reg(jmss_pkg::CSR_SCAN_LIMIT, 24'hFFFFFF);
      write_reg(jmss_pkg::CSR_MARKER_THRESHOLD, {16'($urandom), 8'd1});
      run_files(8, 1'b1);
      drain();

      write_reg(jmss_pkg::CSR_SCAN_LIMIT, 24'd0);
      write_reg(jmss_pkg::CSR_MARKER_THRESHOLD, {16'($urandom), 8'd255});
      run_files(5, 1'b1);
      drain();

      write_reg(jmss_pkg::CSR_SCAN_LIMIT, 24'($urandom_range(4, 40)));
      write_reg(jmss_pkg::CSR_MARKER_THRESHOLD, 24'($urandom_range(1, 8)));
      run_files(8, 1'b1);
      drain();

      // unused index must leave both registers alone
      write_reg(CSR_UNUSED, 24'($urandom));
      write_reg(jmss_pkg::CSR_MARKER_THRESHOLD, 24'($urandom_range(2, 4)));
      run_files(7, 1'b0);
      drain();

      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
